// ===== hw/rtl/ppc_pkg.sv =====
`default_nettype none

package ppc_pkg;

  // Field and register widths.
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned GAIN_SHIFT = GAIN_FRAC - FRAC_BITS;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned LEN_W      = 25;

  // Configuration port geometry.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;

  localparam logic [ANGLE_W-1:0] PEN_ANGLE_MAX = 8'd180;

  // Register reset values.
  localparam logic [CFG_W-1:0]   X_GAIN_RST        = 24'd65536;
  localparam logic [CFG_W-1:0]   Y_GAIN_RST        = 24'd65536;
  localparam logic [CFG_W-1:0]   X_ORIGIN_RST      = 24'd0;
  localparam logic [CFG_W-1:0]   Y_ORIGIN_RST      = 24'd0;
  localparam logic [CFG_W-1:0]   MOTOR_SPACING_RST = 24'd256000;
  localparam logic [ANGLE_W-1:0] PEN_DOWN_RST      = 8'd0;
  localparam logic [ANGLE_W-1:0] PEN_UP_RST        = 8'd180;

  typedef enum logic [2:0] {
    REG_X_GAIN        = 3'd0,
    REG_Y_GAIN        = 3'd1,
    REG_X_ORIGIN      = 3'd2,
    REG_Y_ORIGIN      = 3'd3,
    REG_MOTOR_SPACING = 3'd4,
    REG_PEN_DOWN      = 3'd5,
    REG_PEN_UP        = 3'd6
  } reg_idx_e;

  typedef enum logic {
    CMD_MOVE = 1'b0,
    CMD_PEN  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STEP_MOVE,
    STEP_PEN_DOWN,
    STEP_PEN_UP
  } step_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  path_first;
    logic                  path_last;
  } point_t;

  typedef struct packed {
    cmd_e               command;
    logic [LEN_W-1:0]   left_length;
    logic [LEN_W-1:0]   right_length;
    logic [ANGLE_W-1:0] pen_angle;
    logic               last_of_run;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0]   x_gain;
    logic [CFG_W-1:0]   y_gain;
    logic [CFG_W-1:0]   x_origin;
    logic [CFG_W-1:0]   y_origin;
    logic [CFG_W-1:0]   motor_spacing;
    logic [ANGLE_W-1:0] pen_down_angle;
    logic [ANGLE_W-1:0] pen_up_angle;
  } cfg_t;

  // One computed point waiting for the command sequencer.
  typedef struct packed {
    logic [LEN_W-1:0] left_length;
    logic [LEN_W-1:0] right_length;
    logic             path_first;
    logic             path_last;
  } move_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ppc_cfg_regs.sv =====
`default_nettype none

module ppc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ppc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ppc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output ppc_pkg::cfg_t                   cfg_o
);
  import ppc_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_gain         <= X_GAIN_RST;
      cfg_q.y_gain         <= Y_GAIN_RST;
      cfg_q.x_origin       <= X_ORIGIN_RST;
      cfg_q.y_origin       <= Y_ORIGIN_RST;
      cfg_q.motor_spacing  <= MOTOR_SPACING_RST;
      cfg_q.pen_down_angle <= PEN_DOWN_RST;
      cfg_q.pen_up_angle   <= PEN_UP_RST;
    end else if (wr_en) begin
      case (idx)
        REG_X_GAIN:        cfg_q.x_gain         <= pwdata[CFG_W-1:0];
        REG_Y_GAIN:        cfg_q.y_gain         <= pwdata[CFG_W-1:0];
        REG_X_ORIGIN:      cfg_q.x_origin       <= pwdata[CFG_W-1:0];
        REG_Y_ORIGIN:      cfg_q.y_origin       <= pwdata[CFG_W-1:0];
        REG_MOTOR_SPACING: cfg_q.motor_spacing  <= pwdata[CFG_W-1:0];
        REG_PEN_DOWN:      cfg_q.pen_down_angle <= pwdata[ANGLE_W-1:0];
        REG_PEN_UP:        cfg_q.pen_up_angle   <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_GAIN:        prdata = APB_DATA_W'(cfg_q.x_gain);
      REG_Y_GAIN:        prdata = APB_DATA_W'(cfg_q.y_gain);
      REG_X_ORIGIN:      prdata = APB_DATA_W'(cfg_q.x_origin);
      REG_Y_ORIGIN:      prdata = APB_DATA_W'(cfg_q.y_origin);
      REG_MOTOR_SPACING: prdata = APB_DATA_W'(cfg_q.motor_spacing);
      REG_PEN_DOWN:      prdata = APB_DATA_W'(cfg_q.pen_down_angle);
      REG_PEN_UP:        prdata = APB_DATA_W'(cfg_q.pen_up_angle);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_isqrt_pipe.sv =====
`default_nettype none

// Floor square root, one result bit per pipeline stage.
module ppc_isqrt_pipe #(
  parameter int unsigned ROOT_W = 25
) (
  input  logic                  clk_i,
  input  logic [2*ROOT_W-1:0]   radicand_i,
  output logic [ROOT_W-1:0]     root_o
);
  localparam int unsigned InW   = 2 * ROOT_W;
  localparam int unsigned RemW  = ROOT_W + 1;
  localparam int unsigned WorkW = ROOT_W + 3;

  logic [InW-1:0]    rad_q  [ROOT_W-1];
  logic [RemW-1:0]   rem_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [InW-1:0]    rad_in;
    logic [RemW-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [WorkW-1:0]  work;
    logic [WorkW-1:0]  trial;
    logic [WorkW-1:0]  diff;
    logic              fits;

    if (s == 0) begin : g_first
      assign rad_in  = radicand_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign work  = {rem_in, rad_in[InW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign fits  = (work >= trial);
    assign diff  = work - trial;

    always_ff @(posedge clk_i) begin
      root_q[s] <= {root_in[ROOT_W-2:0], fits};
    end

    if (s < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rad_q[s] <= {rad_in[InW-3:0], 2'b00};
        rem_q[s] <= fits ? diff[RemW-1:0] : work[RemW-1:0];
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_front.sv =====
`default_nettype none

// Scales each accepted point and computes both string lengths.
module ppc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ppc_pkg::cfg_t   cfg_i,
  input  logic            accept_i,
  input  ppc_pkg::point_t point_i,
  output logic            done_o,
  output ppc_pkg::move_t  move_o
);
  import ppc_pkg::*;

  localparam int unsigned ProdW = COORD_BITS + CFG_W;
  localparam int unsigned SqW   = 2 * CFG_W;
  localparam int unsigned RadW  = 2 * LEN_W;
  localparam int unsigned PreD  = 5;
  localparam int unsigned PipeD = PreD + LEN_W;

  function automatic logic [CFG_W-1:0] scale_sat(logic [ProdW-1:0] prod,
                                                 logic [CFG_W-1:0] origin);
    logic [ProdW:0] sum;
    sum = {1'b0, prod >> GAIN_SHIFT} + (ProdW + 1)'(origin);
    return (|sum[ProdW:CFG_W]) ? '1 : sum[CFG_W-1:0];
  endfunction

  logic [PipeD-1:0] vld_q;
  logic [PipeD-1:0] first_q;
  logic [PipeD-1:0] last_q;

  logic [ProdW-1:0] prod_x_q, prod_y_q;
  logic [CFG_W-1:0] xs_q, ys_q;
  logic [CFG_W-1:0] xs3_q, ys3_q, dx_q, dx_d;
  logic [SqW-1:0]   sq_x_q, sq_y_q, sq_d_q;
  logic [RadW-1:0]  rad_l_q, rad_r_q;

  // Valid and path flags travel alongside the arithmetic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeD-2:0], accept_i};
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= {first_q[PipeD-2:0], point_i.path_first};
    last_q  <= {last_q[PipeD-2:0], point_i.path_last};
  end

  assign dx_d = (cfg_i.motor_spacing >= xs_q) ? cfg_i.motor_spacing - xs_q
                                              : xs_q - cfg_i.motor_spacing;

  always_ff @(posedge clk_i) begin
    prod_x_q <= ProdW'(point_i.point_x) * ProdW'(cfg_i.x_gain);
    prod_y_q <= ProdW'(point_i.point_y) * ProdW'(cfg_i.y_gain);
    xs_q     <= scale_sat(prod_x_q, cfg_i.x_origin);
    ys_q     <= scale_sat(prod_y_q, cfg_i.y_origin);
    xs3_q    <= xs_q;
    ys3_q    <= ys_q;
    dx_q     <= dx_d;
    sq_x_q   <= SqW'(xs3_q) * SqW'(xs3_q);
    sq_y_q   <= SqW'(ys3_q) * SqW'(ys3_q);
    sq_d_q   <= SqW'(dx_q) * SqW'(dx_q);
    rad_l_q  <= RadW'(sq_x_q) + RadW'(sq_y_q);
    rad_r_q  <= RadW'(sq_d_q) + RadW'(sq_y_q);
  end

  ppc_isqrt_pipe #(.ROOT_W(LEN_W)) u_sqrt_left (
    .clk_i      (clk_i),
    .radicand_i (rad_l_q),
    .root_o     (move_o.left_length)
  );

  ppc_isqrt_pipe #(.ROOT_W(LEN_W)) u_sqrt_right (
    .clk_i      (clk_i),
    .radicand_i (rad_r_q),
    .root_o     (move_o.right_length)
  );

  assign move_o.path_first = first_q[PipeD-1];
  assign move_o.path_last  = last_q[PipeD-1];
  assign done_o            = vld_q[PipeD-1];

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_queue.sv =====
`default_nettype none

// Queue between the arithmetic pipeline and the command sequencer. A slot is
// reserved when a point is accepted, so the pipeline never has to stall.
module ppc_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           reserve_i,
  output logic           full_o,
  input  logic           push_i,
  input  ppc_pkg::move_t entry_i,
  input  logic           pop_i,
  output logic           empty_o,
  output ppc_pkg::move_t head_o
);
  import ppc_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  move_t           mem_q [DEPTH];
  move_t           head_q;
  logic [PtrW-1:0] wr_q, rd_q, rd_d;
  logic [CntW-1:0] resv_q, fill_q;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_d = pop_i ? ptr_next(rd_q) : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      resv_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      rd_q   <= rd_d;
      resv_q <= resv_q + CntW'(reserve_i) - CntW'(pop_i);
      fill_q <= fill_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // The head is read ahead from the next read address. An item written into
  // an otherwise empty queue goes straight to the head register.
  always_ff @(posedge clk_i) begin
    if (push_i && (wr_q == rd_d)) begin
      head_q <= entry_i;
    end else begin
      head_q <= mem_q[rd_d];
    end
  end

  assign head_o  = head_q;
  assign empty_o = (fill_q == '0);
  assign full_o  = (resv_q == CntW'(DEPTH));

  a_fill_within_reserved : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= resv_q)
    else $error("queue holds more points than were reserved");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> fill_q != CntW'(DEPTH))
    else $error("pipeline wrote into a full queue");

endmodule

`default_nettype wire

// ===== hw/rtl/ppc_back.sv =====
`default_nettype none

// Expands each computed point into its move and pen commands.
module ppc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ppc_pkg::cfg_t    cfg_i,
  input  logic             head_valid_i,
  input  ppc_pkg::move_t   head_i,
  output logic             head_pop_o,
  input  logic             out_pop_i,
  output logic             out_valid_o,
  output ppc_pkg::result_t out_item_o
);
  import ppc_pkg::*;

  function automatic logic [ANGLE_W-1:0] clamp_angle(logic [ANGLE_W-1:0] a);
    return (a > PEN_ANGLE_MAX) ? PEN_ANGLE_MAX : a;
  endfunction

  step_e   step_q, step_d;
  logic    out_valid_q;
  result_t out_item_q, item_d;
  logic    load, done;

  assign load = head_valid_i && (!out_valid_q || out_pop_i);

  always_comb begin
    step_d = step_q;
    if (load) begin
      case (step_q)
        STEP_MOVE: begin
          if (head_i.path_first) begin
            step_d = STEP_PEN_DOWN;
          end else if (head_i.path_last) begin
            step_d = STEP_PEN_UP;
          end
        end
        STEP_PEN_DOWN: step_d = head_i.path_last ? STEP_PEN_UP : STEP_MOVE;
        default:       step_d = STEP_MOVE;
      endcase
    end
  end

  always_comb begin
    item_d = '0;
    done   = 1'b1;
    case (step_q)
      STEP_MOVE: begin
        item_d.command      = CMD_MOVE;
        item_d.left_length  = head_i.left_length;
        item_d.right_length = head_i.right_length;
        done                = !(head_i.path_first || head_i.path_last);
      end
      STEP_PEN_DOWN: begin
        item_d.command   = CMD_PEN;
        item_d.pen_angle = clamp_angle(cfg_i.pen_down_angle);
        done             = !head_i.path_last;
      end
      STEP_PEN_UP: begin
        item_d.command   = CMD_PEN;
        item_d.pen_angle = clamp_angle(cfg_i.pen_up_angle);
      end
      default: ;
    endcase
    item_d.last_of_run = done;
  end

  assign head_pop_o = load && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_MOVE;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_pen_step_needs_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && step_q != STEP_MOVE) |-> (head_i.path_first || head_i.path_last))
    else $error("pen command sequenced for a point without path flags");

  a_pen_up_ends_point : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && step_q == STEP_PEN_UP) |=> (step_q == STEP_MOVE))
    else $error("sequencer did not return to move after pen-up");

endmodule

`default_nettype wire

// ===== hw/rtl/polar_plotter_point_to_command.sv =====
`default_nettype none

// Channel    | Direction | Handshake                 | Payload
// -----------+-----------+---------------------------+--------------------------------
// points     | in        | push / full               | in_item_i  (ppc_pkg::point_t)
// commands   | out       | pop / empty               | out_item_o (ppc_pkg::result_t)
// registers  | in/out    | psel penable pwrite pready| paddr, pwdata, prdata
//
// An accepted point reaches the result ports as a move command through two
// scaling stages, a difference stage, a squaring stage, a sum stage, 25
// square-root stages, the queue write and the output register. The result
// side delivers one command per cycle while the consumer keeps popping, and a
// point yields one to three commands; the input side takes one point per cycle
// while queue credits remain (QUEUE_DEPTH points between acceptance and sequencing).
// Reset clears all control state at once; there is no clearing pass.
// A stall on the result side fills the queue and then raises full.

module polar_plotter_point_to_command #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Point input
  input  logic                            push,
  output logic                            full,
  input  ppc_pkg::point_t                 in_item_i,
  // Command output
  output logic                            empty,
  input  logic                            pop,
  output ppc_pkg::result_t                out_item_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ppc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ppc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ppc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import ppc_pkg::*;

  cfg_t  cfg;
  logic  accept;
  logic  front_done;
  move_t front_move;
  logic  q_empty, q_full, q_pop;
  move_t q_head;
  logic  out_valid;

  // Scale, gain and angle registers, read directly by the pipeline without any
  // snapshot. The user must change them only while the block is idle (not enforced).
  ppc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A point is taken whenever a queue slot is free. The slot is reserved at
  // acceptance, which is what lets the arithmetic pipeline run without any
  // stall of its own.
  assign accept = push && !q_full;
  assign full   = q_full;

  // Front: scaling, motor offset, squares and the two square roots.
  ppc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .point_i  (in_item_i),
    .done_o   (front_done),
    .move_o   (front_move)
  );

  // Decoupling queue holding finished string lengths and the path flags.
  ppc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .reserve_i (accept),
    .full_o    (q_full),
    .push_i    (front_done),
    .entry_i   (front_move),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_o    (q_head)
  );

  // Back: turns each queued point into a move, an optional pen-down and an
  // optional pen-up, through an output register that keeps loading while the
  // consumer takes the previous command.
  ppc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (!q_empty),
    .head_i       (q_head),
    .head_pop_o   (q_pop),
    .out_pop_i    (pop && out_valid),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item_o)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== bench/tb_polar_plotter_point_to_command.sv =====
`timescale 1ns / 100ps

module tb_polar_plotter_point_to_command;
  import ppc_pkg::*;

  // The run ends here at the latest, a wide margin for a correct run even with
  // the heaviest stalls.
  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS = 10;
  // After the last expected command we watch this long for anything extra.
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam logic [63:0] CANVAS_MAX  = 64'hFF_FFFF;
  // A register index that the block does not decode. Writes to it must be ignored.
  localparam logic [2:0]  REG_UNMAPPED = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Point side.
  logic    push     = 1'b0;
  logic    full;
  point_t  point_in = '0;

  // Command side.
  logic    empty;
  logic    pop = 1'b0;
  result_t cmd_out;

  // Register port.
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  polar_plotter_point_to_command DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (point_in),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (cmd_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Points waiting to be offered to the block, and the commands that the
  // accepted points must still produce, oldest first.
  point_t  point_backlog[$];
  result_t cmd_expect_q[$];

  // Our own copy of the register file, updated when a write completes.
  cfg_t model_cfg;

  // Pacing knobs, in percent of cycles.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  int unsigned fault_count      = 0;
  int unsigned points_taken     = 0;
  int unsigned commands_checked = 0;
  int unsigned setups_used      = 0;
  int unsigned cycle_count      = 0;
  logic        point_refused    = 1'b0;
  result_t     want;

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // Floor of the square root, found one result bit at a time from the top.
  function automatic logic [LEN_W-1:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root[LEN_W-1:0];
  endfunction

  // Drawing coordinate to Q16.8 canvas units: truncated gain product, then the
  // origin, then saturation at the top of the 24-bit range.
  function automatic logic [63:0] to_canvas(input logic [COORD_BITS-1:0] c,
                                            input logic [CFG_W-1:0] gain,
                                            input logic [CFG_W-1:0] origin);
    logic [63:0] v;
    v = ((64'(c) * 64'(gain)) >> GAIN_SHIFT) + 64'(origin);
    return (v > CANVAS_MAX) ? CANVAS_MAX : v;
  endfunction

  function automatic logic [ANGLE_W-1:0] servo_limit(input logic [ANGLE_W-1:0] a);
    return (a > PEN_ANGLE_MAX) ? PEN_ANGLE_MAX : a;
  endfunction

  // Every point yields a move. A path start adds pen-down, a path end adds
  // pen-up, in that order; the last command of the point carries last_of_run.
  function automatic void predict_commands(input point_t p);
    logic [63:0] xs;
    logic [63:0] ys;
    logic [63:0] dx;
    result_t     r;
    xs = to_canvas(p.point_x, model_cfg.x_gain, model_cfg.x_origin);
    ys = to_canvas(p.point_y, model_cfg.y_gain, model_cfg.y_origin);
    // When the point lies right of the motor, the distance is taken the other way.
    if (64'(model_cfg.motor_spacing) >= xs) begin
      dx = 64'(model_cfg.motor_spacing) - xs;
    end else begin
      dx = xs - 64'(model_cfg.motor_spacing);
    end
    r              = '0;
    r.command      = CMD_MOVE;
    r.left_length  = floor_root(xs * xs + ys * ys);
    r.right_length = floor_root(dx * dx + ys * ys);
    r.last_of_run  = !(p.path_first || p.path_last);
    cmd_expect_q.push_back(r);
    if (p.path_first) begin
      r             = '0;
      r.command     = CMD_PEN;
      r.pen_angle   = servo_limit(model_cfg.pen_down_angle);
      r.last_of_run = !p.path_last;
      cmd_expect_q.push_back(r);
    end
    if (p.path_last) begin
      r             = '0;
      r.command     = CMD_PEN;
      r.pen_angle   = servo_limit(model_cfg.pen_up_angle);
      r.last_of_run = 1'b1;
      cmd_expect_q.push_back(r);
    end
  endfunction

  // Point driver. It changes push and the point at the falling edge. An item
  // that was refused stays on the port until the block takes it.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (push && point_refused) begin
      push <= 1'b1;
    end else if (point_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      push     <= 1'b1;
      point_in <= point_backlog[0];
    end else begin
      push <= 1'b0;
    end
  end

  // Acceptance of a point. The prediction is made with the registers in force
  // now, which cannot change while points are in flight.
  always @(posedge clk_i) begin
    point_refused <= push && full;
    if (rst_ni && push && !full) begin
      predict_commands(point_in);
      void'(point_backlog.pop_front());
      points_taken++;
    end
  end

  // Command receiver. Pop may be high while the block is empty.
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Command checker. Each command taken must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (cmd_expect_q.size() == 0) begin
        log_fault($sformatf("unexpected command: cmd=%0d left=%0d right=%0d angle=%0d last=%0b",
                            cmd_out.command, cmd_out.left_length, cmd_out.right_length,
                            cmd_out.pen_angle, cmd_out.last_of_run));
      end else begin
        want = cmd_expect_q.pop_front();
        commands_checked++;
        if (cmd_out.command !== want.command ||
            cmd_out.left_length !== want.left_length ||
            cmd_out.right_length !== want.right_length ||
            cmd_out.pen_angle !== want.pen_angle ||
            cmd_out.last_of_run !== want.last_of_run) begin
          log_fault($sformatf({"command mismatch: expected cmd=%0d left=%0d right=%0d ",
                               "angle=%0d last=%0b, got cmd=%0d left=%0d right=%0d ",
                               "angle=%0d last=%0b"},
                              want.command, want.left_length, want.right_length,
                              want.pen_angle, want.last_of_run,
                              cmd_out.command, cmd_out.left_length, cmd_out.right_length,
                              cmd_out.pen_angle, cmd_out.last_of_run));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("polar_plotter_point_to_command verification failed");
    $finish;
  end

  // One register access: a setup phase, then an access phase that lasts until
  // pready is seen high. Read data is taken at the completing edge.
  task automatic reg_access(input logic [2:0] idx, input logic is_write,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes carry random junk above the register width; the block keeps only
  // the low bits, and so does our copy.
  task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] data);
    logic [APB_DATA_W-1:0] unused;
    reg_access(idx, 1'b1, data, unused);
    case (idx)
      REG_X_GAIN:        model_cfg.x_gain         = data[CFG_W-1:0];
      REG_Y_GAIN:        model_cfg.y_gain         = data[CFG_W-1:0];
      REG_X_ORIGIN:      model_cfg.x_origin       = data[CFG_W-1:0];
      REG_Y_ORIGIN:      model_cfg.y_origin       = data[CFG_W-1:0];
      REG_MOTOR_SPACING: model_cfg.motor_spacing  = data[CFG_W-1:0];
      REG_PEN_DOWN:      model_cfg.pen_down_angle = data[ANGLE_W-1:0];
      REG_PEN_UP:        model_cfg.pen_up_angle   = data[ANGLE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [APB_DATA_W-1:0] with_junk(input logic [CFG_W-1:0] field,
                                                      input int unsigned width);
    logic [APB_DATA_W-1:0] junk;
    junk = $urandom;
    return (junk << width) | APB_DATA_W'(field);
  endfunction

  // Reads every decoded register back and compares it with our copy.
  task automatic check_regs();
    logic [APB_DATA_W-1:0] got;
    logic [APB_DATA_W-1:0] held;
    logic [2:0]            idx;
    for (int i = 0; i < REG_UNMAPPED; i++) begin
      idx = 3'(i);
      reg_access(idx, 1'b0, '0, got);
      case (idx)
        REG_X_GAIN:        held = APB_DATA_W'(model_cfg.x_gain);
        REG_Y_GAIN:        held = APB_DATA_W'(model_cfg.y_gain);
        REG_X_ORIGIN:      held = APB_DATA_W'(model_cfg.x_origin);
        REG_Y_ORIGIN:      held = APB_DATA_W'(model_cfg.y_origin);
        REG_MOTOR_SPACING: held = APB_DATA_W'(model_cfg.motor_spacing);
        REG_PEN_DOWN:      held = APB_DATA_W'(model_cfg.pen_down_angle);
        default:           held = APB_DATA_W'(model_cfg.pen_up_angle);
      endcase
      if (got !== held) begin
        log_fault($sformatf("register %0d reads 0x%0h, expected 0x%0h", idx, got, held));
      end
    end
  endtask

  task automatic setup_regs(input logic [CFG_W-1:0] xg, input logic [CFG_W-1:0] yg,
                            input logic [CFG_W-1:0] xo, input logic [CFG_W-1:0] yo,
                            input logic [CFG_W-1:0] ms, input logic [ANGLE_W-1:0] down,
                            input logic [ANGLE_W-1:0] up);
    write_reg(REG_X_GAIN, with_junk(xg, CFG_W));
    write_reg(REG_Y_GAIN, with_junk(yg, CFG_W));
    write_reg(REG_X_ORIGIN, with_junk(xo, CFG_W));
    write_reg(REG_Y_ORIGIN, with_junk(yo, CFG_W));
    write_reg(REG_MOTOR_SPACING, with_junk(ms, CFG_W));
    write_reg(REG_PEN_DOWN, with_junk(CFG_W'(down), ANGLE_W));
    write_reg(REG_PEN_UP, with_junk(CFG_W'(up), ANGLE_W));
    check_regs();
    setups_used++;
  endtask

  function automatic void add_point(input logic [COORD_BITS-1:0] x,
                                    input logic [COORD_BITS-1:0] y,
                                    input logic first, input logic last);
    point_backlog.push_back(point_t'{x, y, first, last});
  endfunction

  // Mostly full-range coordinates, with a share near the origin where the
  // scaled point usually stays clear of saturation.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    if ($urandom_range(3) == 0) begin
      return COORD_BITS'($urandom_range(0, 2000));
    end
    return COORD_BITS'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    if ($urandom_range(3) == 0) begin
      return CFG_W'($urandom);
    end
    return CFG_W'($urandom_range(24'h00_1000, 24'h02_0000));
  endfunction

  function automatic logic [CFG_W-1:0] pick_origin();
    if ($urandom_range(3) == 0) begin
      return CFG_W'($urandom);
    end
    return CFG_W'($urandom_range(0, 24'h02_0000));
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(3) == 0) begin
      return ANGLE_W'($urandom_range(181, 255));
    end
    return ANGLE_W'($urandom_range(0, 180));
  endfunction

  // Queues whole paths: a first point, some interior points, a last point.
  // A path of one point carries both flags. About one path in five gets
  // random flags instead, to mimic broken or overlapping paths.
  task automatic queue_paths(input int unsigned count);
    int unsigned made;
    int unsigned span;
    logic        scrambled;
    made = 0;
    while (made < count) begin
      span      = $urandom_range(1, 6);
      scrambled = ($urandom_range(99) < 20);
      for (int unsigned k = 0; k < span && made < count; k++) begin
        if (scrambled) begin
          add_point(pick_coord(), pick_coord(), 1'($urandom), 1'($urandom));
        end else begin
          add_point(pick_coord(), pick_coord(), k == 0, k == span - 1);
        end
        made++;
      end
    end
  endtask

  // Waits until every queued point has been taken and every
  // predicted command has come out. Registers may be written after this.
  task automatic wait_idle();
    while (point_backlog.size() != 0 || cmd_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    model_cfg = '{x_gain: X_GAIN_RST, y_gain: Y_GAIN_RST, x_origin: X_ORIGIN_RST,
                  y_origin: Y_ORIGIN_RST, motor_spacing: MOTOR_SPACING_RST,
                  pen_down_angle: PEN_DOWN_RST, pen_up_angle: PEN_UP_RST};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The registers must come out of reset with their documented values.
    check_regs();
    setups_used++;

    // Directed points at the reset setting: unit gain, motors 1000 units apart.
    add_point('0, '0, 1'b0, 1'b0);               // origin, move only
    add_point('1, '1, 1'b1, 1'b1);               // largest point, all three commands
    add_point(16'd1000, 16'd300, 1'b1, 1'b0);    // right under the right motor
    add_point(16'd1500, 16'd200, 1'b0, 1'b1);    // right of the right motor
    add_point('1, '0, 1'b0, 1'b0);
    add_point('0, '1, 1'b1, 1'b0);
    add_point(16'd255, 16'd1, 1'b0, 1'b1);
    wait_idle();

    // Largest gains and origins saturate both coordinates; motors at zero
    // spacing; pen angles above the servo range must be clamped.
    setup_regs('1, '1, '1, '1, '0, 8'd255, 8'd181);
    // A write to an undecoded index must leave every register untouched.
    write_reg(REG_UNMAPPED, $urandom);
    check_regs();
    add_point('0, '0, 1'b1, 1'b1);
    add_point('1, '1, 1'b0, 1'b0);
    add_point(16'd1, '0, 1'b1, 1'b0);
    add_point('0, 16'd1, 1'b0, 1'b1);
    wait_idle();

    // Zero gains and origins pin the point to the canvas origin; motors as far
    // apart as the register allows; angles at both ends of the servo range.
    setup_regs('0, '0, '0, '0, '1, PEN_ANGLE_MAX, 8'd0);
    add_point('1, '0, 1'b0, 1'b1);
    add_point('0, '1, 1'b1, 1'b1);
    add_point('1, '1, 1'b1, 1'b0);
    wait_idle();

    // Random part: eight phases of forty points, each with a fresh register
    // setting. The pacing cycles through four modes: none, a slow sender, a
    // slow receiver, and both. Halfway through each phase the sender waits
    // until the block has drained completely.
    for (int unsigned phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 62;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 62;
        end
        default: begin
          sender_idle_pct    = 32;
          receiver_stall_pct = 32;
        end
      endcase
      setup_regs(pick_gain(), pick_gain(), pick_origin(), pick_origin(),
                 CFG_W'($urandom_range(24'h01_0000, 24'h80_0000)),
                 pick_angle(), pick_angle());
      queue_paths(20);
      wait_idle();
      queue_paths(20);
      wait_idle();
    end

    // Watch a while longer for stray commands before judging the run.
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (cmd_expect_q.size() != 0) begin
      log_fault($sformatf("%0d expected commands never came out", cmd_expect_q.size()));
    end

    $display("Covered %0d points and %0d commands under %0d register settings,",
             points_taken, commands_checked, setups_used);
    $display("with free-running, slow-sender, slow-receiver and mixed pacing; %0d faults.",
             fault_count);
    if (fault_count == 0) begin
      $display("polar_plotter_point_to_command verification clean");
    end else begin
      $display("polar_plotter_point_to_command verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ppc_pkg.sv
hw/rtl/ppc_cfg_regs.sv
hw/rtl/ppc_isqrt_pipe.sv
hw/rtl/ppc_front.sv
hw/rtl/ppc_queue.sv
hw/rtl/ppc_back.sv
hw/rtl/polar_plotter_point_to_command.sv
bench/tb_polar_plotter_point_to_command.sv
